// ===== design/iad_pkg.sv =====
// Shared constants, types and lookup functions for the IMA ADPCM block decoder.
`default_nettype none
package iad_pkg;

  localparam int MAX_BLOCK_FRAMES = 4096;
  // Bits needed to hold a block frame count up to MAX_BLOCK_FRAMES.
  localparam int BLK_W            = $clog2(MAX_BLOCK_FRAMES + 1);
  localparam int TRK_W            = 24;
  localparam int HDR_BYTES        = 5;            // header bytes kept before the last one
  localparam logic [2:0] HDR_LAST = 3'd5;         // position of the closing header byte
  localparam logic [6:0] STEP_MAX = 7'd88;
  localparam logic signed [17:0] PRED_MIN = -18'sd32768;
  localparam logic signed [17:0] PRED_MAX = 18'sd32767;

  // Result status codes.
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_BAD_HDR = 1'b1;

  typedef logic [14:0] step_t;
  typedef logic signed [15:0] sample_t;

  // Step-size table; positions 88 and above read as 32767.
  function automatic step_t step_size(input logic [6:0] pos);
    step_t s;
    unique case (pos)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;     7'd3:  s = 15'd10;
      7'd4:  s = 15'd11;    7'd5:  s = 15'd12;    7'd6:  s = 15'd13;    7'd7:  s = 15'd14;
      7'd8:  s = 15'd16;    7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;    7'd15: s = 15'd31;
      7'd16: s = 15'd34;    7'd17: s = 15'd37;    7'd18: s = 15'd41;    7'd19: s = 15'd45;
      7'd20: s = 15'd50;    7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;    7'd27: s = 15'd97;
      7'd28: s = 15'd107;   7'd29: s = 15'd118;   7'd30: s = 15'd130;   7'd31: s = 15'd143;
      7'd32: s = 15'd157;   7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;   7'd39: s = 15'd307;
      7'd40: s = 15'd337;   7'd41: s = 15'd371;   7'd42: s = 15'd408;   7'd43: s = 15'd449;
      7'd44: s = 15'd494;   7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;   7'd51: s = 15'd963;
      7'd52: s = 15'd1060;  7'd53: s = 15'd1166;  7'd54: s = 15'd1282;  7'd55: s = 15'd1411;
      7'd56: s = 15'd1552;  7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;  7'd63: s = 15'd3024;
      7'd64: s = 15'd3327;  7'd65: s = 15'd3660;  7'd66: s = 15'd4026;  7'd67: s = 15'd4428;
      7'd68: s = 15'd4871;  7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;  7'd75: s = 15'd9493;
      7'd76: s = 15'd10442; 7'd77: s = 15'd11487; 7'd78: s = 15'd12635; 7'd79: s = 15'd13899;
      7'd80: s = 15'd15289; 7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086; 7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  // Step position adjustment for the magnitude bits of a nibble.
  function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
    logic signed [4:0] a;
    unique case (mag)
      3'd4:    a = 5'sd2;
      3'd5:    a = 5'sd4;
      3'd6:    a = 5'sd6;
      3'd7:    a = 5'sd8;
      default: a = -5'sd1;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== design/iad_nibble.sv =====
// One ADPCM nibble decode: predictor update with saturation and step position update.
`default_nettype none
module iad_nibble
  import iad_pkg::*;
(
  input  wire logic [3:0] nib,
  input  wire sample_t    pred,
  input  wire logic [6:0] step_pos,
  output sample_t         pred_new,
  output logic [6:0]      step_pos_new
);

  step_t              step;
  logic [16:0]        diff;
  logic signed [17:0] sum;
  logic signed [7:0]  np;
  logic signed [4:0]  adj;

  always_comb begin
    step = step_size(step_pos);
    diff = 17'(step >> 3);
    if (nib[0]) diff = diff + 17'(step >> 2);
    if (nib[1]) diff = diff + 17'(step >> 1);
    if (nib[2]) diff = diff + 17'(step);
    if (nib[3]) sum = {{2{pred[15]}}, pred} - $signed({1'b0, diff});
    else        sum = {{2{pred[15]}}, pred} + $signed({1'b0, diff});
    if (sum < PRED_MIN)      pred_new = PRED_MIN[15:0];
    else if (sum > PRED_MAX) pred_new = PRED_MAX[15:0];
    else                     pred_new = sum[15:0];

    adj = index_adjust(nib[2:0]);
    np  = $signed({1'b0, step_pos}) + {{3{adj[4]}}, adj};
    if (np < 8'sd0)                          step_pos_new = 7'd0;
    else if (np > $signed({1'b0, STEP_MAX})) step_pos_new = STEP_MAX;
    else                                     step_pos_new = np[6:0];
  end

endmodule
`default_nettype wire

// ===== design/ima_adpcm_block_decoder.sv =====
// Top level of the IMA ADPCM block decoder: header parsing, frame counting, result register.
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+----------------------------------------------
//  in_       | in  | in_tvalid / in_tready  | in_tdata[7:0] = data_byte
//  out_      | out | out_tvalid / out_tready| out_tdata = sample, out_tuser = {track_end,
//            |     |                        | status}, out_tlast = last
//  cfg_      | in  | cfg_valid / cfg_ready  | cfg_data[23:0] = track length in frames
//
// Order: a data byte is decoded one nibble at a time, low nibble first, since the high
//   nibble's sample needs the predictor left by the low nibble through the shared
//   nibble decoder. The next byte can enter the input register while the high nibble waits.
// Datapath: results are decoded combinationally from the input byte or held high nibble.
// Reset: synchronous on rst_n; expects a header, counters zero, track length all ones.
// Stalls: a one-entry input register takes a byte while a result waits in the output
//   register; header bytes that give no result drain even while the output is stalled.
`default_nettype none
module ima_adpcm_block_decoder
  import iad_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,     // [7:0] data_byte
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [15:0]       out_tdata,    // [15:0] sample
  output logic [1:0]        out_tuser,    // [0] status, [1] track_end
  output logic              out_tlast,    // last result of the input byte
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [23:0]  cfg_data      // [23:0] track length in frames
);

  // Configuration
  logic [TRK_W-1:0] trk_frames_r;

  // Input register
  logic       in_full_r, in_full_nxt;
  logic [7:0] in_byte_r;

  // Decoder state
  logic             in_header_r, in_header_nxt;
  logic [2:0]       hdr_pos_r, hdr_pos_nxt;
  logic [7:0]       hdr_r [HDR_BYTES];
  sample_t          pred_r, pred_nxt;
  logic [6:0]       step_r, step_nxt;
  logic [BLK_W-1:0] blk_rem_r, blk_rem_nxt;
  logic [TRK_W-1:0] trk_rem_r, trk_rem_nxt;
  logic             hi_pend_r, hi_pend_nxt;
  logic [3:0]       hi_nib_r, hi_nib_nxt;

  // Result register
  logic    out_valid_r, out_valid_nxt;
  sample_t out_smp_r, out_smp_nxt;
  logic    out_st_r, out_st_nxt;
  logic    out_te_r, out_te_nxt;
  logic    out_last_r, out_last_nxt;

  logic             can_load, hdr_fill, do_hi, do_in, in_acc;
  logic [3:0]       nib;
  sample_t          nib_pred;
  logic [6:0]       nib_step;
  logic [15:0]      hdr_count;
  logic [TRK_W-1:0] trk_eff;
  logic             hdr_bad;
  logic [BLK_W-1:0] blk_dec;
  logic [TRK_W-1:0] trk_dec;
  logic             trk_hit;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid & in_tready;

  // The output register can take a new result this cycle.
  assign can_load  = !out_valid_r || out_tready;
  // Header bytes before the closing one give no result.
  assign hdr_fill  = in_header_r && (hdr_pos_r != HDR_LAST);
  assign do_hi     = hi_pend_r && can_load;
  assign do_in     = in_full_r && !hi_pend_r && (hdr_fill || can_load);
  assign in_tready = !in_full_r || do_in;

  assign nib = hi_pend_r ? hi_nib_r : in_byte_r[3:0];

  iad_nibble u_nibble (
    .nib          (nib),
    .pred         (pred_r),
    .step_pos     (step_r),
    .pred_new     (nib_pred),
    .step_pos_new (nib_step)
  );

  // Header check; track counter reloads when empty before the count is compared.
  assign hdr_count = {hdr_r[1], hdr_r[0]};
  assign trk_eff   = (trk_rem_r == '0) ? trk_frames_r : trk_rem_r;
  assign hdr_bad   = (hdr_count == 16'd0)
                  || ({16'd0, hdr_count} > 32'(MAX_BLOCK_FRAMES))
                  || ({8'd0, hdr_count} > trk_eff)
                  || (hdr_r[4] > {1'b0, STEP_MAX})
                  || (in_byte_r != 8'd0);

  // Frame counting for data samples.
  assign blk_dec = blk_rem_r - 1'b1;
  assign trk_dec = (trk_rem_r != '0) ? trk_rem_r - 1'b1 : trk_rem_r;
  assign trk_hit = (trk_rem_r == TRK_W'(1));

  always_comb begin
    in_full_nxt   = in_full_r;
    in_header_nxt = in_header_r;
    hdr_pos_nxt   = hdr_pos_r;
    pred_nxt      = pred_r;
    step_nxt      = step_r;
    blk_rem_nxt   = blk_rem_r;
    trk_rem_nxt   = trk_rem_r;
    hi_pend_nxt   = hi_pend_r;
    hi_nib_nxt    = hi_nib_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_smp_nxt   = out_smp_r;
    out_st_nxt    = out_st_r;
    out_te_nxt    = out_te_r;
    out_last_nxt  = out_last_r;

    if (in_acc)     in_full_nxt = 1'b1;
    else if (do_in) in_full_nxt = 1'b0;

    if (do_hi) begin
      // High nibble of the byte whose low nibble gave the previous result.
      pred_nxt      = nib_pred;
      step_nxt      = nib_step;
      blk_rem_nxt   = blk_dec;
      trk_rem_nxt   = trk_dec;
      hi_pend_nxt   = 1'b0;
      in_header_nxt = (blk_dec == '0);
      out_valid_nxt = 1'b1;
      out_smp_nxt   = nib_pred;
      out_st_nxt    = ST_OK;
      out_te_nxt    = trk_hit;
      out_last_nxt  = 1'b1;
    end else if (do_in) begin
      if (hdr_fill) begin
        hdr_pos_nxt = hdr_pos_r + 3'd1;
      end else if (in_header_r) begin
        // Closing header byte: one result, good or bad.
        hdr_pos_nxt   = 3'd0;
        trk_rem_nxt   = trk_eff;
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        if (hdr_bad) begin
          out_smp_nxt = '0;
          out_st_nxt  = ST_BAD_HDR;
          out_te_nxt  = 1'b0;
        end else begin
          pred_nxt      = {hdr_r[3], hdr_r[2]};
          step_nxt      = hdr_r[4][6:0];
          blk_rem_nxt   = hdr_count[BLK_W-1:0] - 1'b1;
          trk_rem_nxt   = trk_eff - 1'b1;
          in_header_nxt = (hdr_count == 16'd1);
          out_smp_nxt   = {hdr_r[3], hdr_r[2]};
          out_st_nxt    = ST_OK;
          out_te_nxt    = (trk_eff == TRK_W'(1));
        end
      end else begin
        // Low nibble; the high nibble follows unless the block is used up.
        pred_nxt      = nib_pred;
        step_nxt      = nib_step;
        blk_rem_nxt   = blk_dec;
        trk_rem_nxt   = trk_dec;
        out_valid_nxt = 1'b1;
        out_smp_nxt   = nib_pred;
        out_st_nxt    = ST_OK;
        out_te_nxt    = trk_hit;
        if (blk_dec == '0) begin
          in_header_nxt = 1'b1;
          out_last_nxt  = 1'b1;
        end else begin
          out_last_nxt = 1'b0;
          hi_pend_nxt  = 1'b1;
          hi_nib_nxt   = in_byte_r[7:4];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_frames_r <= '1;
      in_full_r    <= 1'b0;
      in_header_r  <= 1'b1;
      hdr_pos_r    <= 3'd0;
      pred_r       <= '0;
      step_r       <= '0;
      blk_rem_r    <= '0;
      trk_rem_r    <= '0;
      hi_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) trk_frames_r <= cfg_data;
      in_full_r   <= in_full_nxt;
      in_header_r <= in_header_nxt;
      hdr_pos_r   <= hdr_pos_nxt;
      pred_r      <= pred_nxt;
      step_r      <= step_nxt;
      blk_rem_r   <= blk_rem_nxt;
      trk_rem_r   <= trk_rem_nxt;
      hi_pend_r   <= hi_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (in_acc) in_byte_r <= in_tdata;
    if (do_in && hdr_fill) hdr_r[hdr_pos_r] <= in_byte_r;
    hi_nib_r   <= hi_nib_nxt;
    out_smp_r  <= out_smp_nxt;
    out_st_r   <= out_st_nxt;
    out_te_r   <= out_te_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_smp_r;
  assign out_tuser  = {out_te_r, out_st_r};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ===== design/iad_checker.sv =====
// Port-level checker for the IMA ADPCM block decoder, bound to the top level.
`default_nettype none
module iad_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // A header error reads as sample zero, no track end, and closes its byte.
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 16'd0 && !out_tuser[1] && out_tlast)
    else $error("malformed error result");

  // Only a data byte's low nibble leaves the byte open, never an error.
  a_open_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !out_tuser[0])
    else $error("error result without last");

  // No result straight out of reset.
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind ima_adpcm_block_decoder iad_checker u_iad_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
